// File: sv/led_surge_pattern_sequencer_unit_macros.svh
// assertion macros for the led surge pattern sequencer
// used by the top level; needs nothing else
`ifndef LED_SURGE_PATTERN_SEQUENCER_UNIT_MACROS_SVH
`define LED_SURGE_PATTERN_SEQUENCER_UNIT_MACROS_SVH

// same-cycle implication, off while reset is asserted
`define LSPS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off while reset is asserted
`define LSPS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/lsps_pkg.sv
// shared types, constants and color table of the led surge pattern sequencer
// no dependencies
`timescale 1ns / 1ps

package lsps_pkg;

    localparam int SURGE_LENGTH_DEF = 100;
    localparam int GAP_LENGTH_DEF   = 20;
    localparam int REST_LENGTH_DEF  = 60;

    localparam int PEAK_LEVEL = 64;
    localparam int LEVEL_W    = 7;
    localparam int PATTERN_W  = 4;

    localparam logic [PATTERN_W-1:0] PATTERN_DARK  = 4'd0;
    localparam logic [PATTERN_W-1:0] PATTERN_RESET = 4'd1;
    localparam logic [PATTERN_W-1:0] PATTERN_MAX   = 4'd9;

    localparam logic OP_TICK    = 1'b0;
    localparam logic OP_REQUEST = 1'b1;

    typedef enum logic [2:0] {
        HUE_NONE   = 3'd0,
        HUE_BLUE   = 3'd1,
        HUE_RED    = 3'd2,
        HUE_GREEN  = 3'd3,
        HUE_YELLOW = 3'd4,
        HUE_WHITE  = 3'd5
    } t_hue;

    typedef struct packed {
        logic                 operation;
        logic [PATTERN_W-1:0] pattern_request;
    } t_in;

    typedef struct packed {
        logic [LEVEL_W-1:0]   green_level;
        logic [LEVEL_W-1:0]   red_level;
        logic [LEVEL_W-1:0]   blue_level;
        logic [PATTERN_W-1:0] active_pattern;
    } t_out;

    // color of one surge of a pattern
    function automatic t_hue hue_of(input logic [PATTERN_W-1:0] pattern,
                                    input logic second);
        t_hue hue;
        case (pattern)
            4'd1:    hue = HUE_BLUE;
            4'd2:    hue = HUE_RED;
            4'd3:    hue = HUE_GREEN;
            4'd4:    hue = HUE_YELLOW;
            4'd5:    hue = HUE_WHITE;
            4'd6:    hue = second ? HUE_RED    : HUE_BLUE;
            4'd7:    hue = second ? HUE_GREEN  : HUE_BLUE;
            4'd8:    hue = second ? HUE_YELLOW : HUE_BLUE;
            4'd9:    hue = second ? HUE_WHITE  : HUE_BLUE;
            default: hue = HUE_NONE;
        endcase
        return hue;
    endfunction

endpackage

// File: sv/led_surge_pattern_sequencer_unit.sv
// top level of the led surge pattern sequencer: pattern state, phase counter, result register
// depends on lsps_pkg, lsps_pixel and the assertion macro header
`timescale 1ns / 1ps
`include "led_surge_pattern_sequencer_unit_macros.svh"

// One transfer per clock in, one per clock out, unless stalled. A pattern request (0..9, others
// ignored) only updates the pending pattern and gives no result. A tick applies a pending change,
// resetting the phase, and yields one GRB pixel in the result register on the next cycle; a new
// item is taken every cycle while that register is empty or being drained, so the rate is set by
// the single result register alone. The phase runs over 2*SURGE_LENGTH+GAP_LENGTH+REST_LENGTH
// ticks; pattern 0 is dark and holds the phase at 0. No clearing pass after reset.
module led_surge_pattern_sequencer_unit
    import lsps_pkg::*;
#(
    parameter int SURGE_LENGTH = SURGE_LENGTH_DEF,
    parameter int GAP_LENGTH   = GAP_LENGTH_DEF,
    parameter int REST_LENGTH  = REST_LENGTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data
);

    localparam int CYCLE   = 2 * SURGE_LENGTH + GAP_LENGTH + REST_LENGTH;
    localparam int PHASE_W = $clog2(CYCLE);

    logic [PATTERN_W-1:0] r_active;
    logic [PATTERN_W-1:0] n_active;
    logic [PATTERN_W-1:0] r_pending;
    logic [PATTERN_W-1:0] n_pending;
    logic [PHASE_W-1:0]   r_phase;
    logic [PHASE_W-1:0]   n_phase;
    logic                 r_out_valid;
    logic                 n_out_valid;
    t_out                 r_out;
    t_out                 n_out;

    logic                 w_accept;
    logic                 w_tick;
    logic [PHASE_W-1:0]   w_cur_phase;
    logic [PHASE_W:0]     w_phase_inc;
    t_out                 w_pixel;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_tick     = w_accept && (i_in_data.operation == OP_TICK);

    // phase seen by this tick, after a pending change takes effect
    assign w_cur_phase = (r_active != r_pending) ? '0 : r_phase;
    assign w_phase_inc = {1'b0, w_cur_phase} + (PHASE_W + 1)'(1);

    lsps_pixel #(
        .SURGE_LENGTH (SURGE_LENGTH),
        .GAP_LENGTH   (GAP_LENGTH),
        .REST_LENGTH  (REST_LENGTH),
        .PHASE_W      (PHASE_W)
    ) u_pixel (
        .i_pattern (r_pending),
        .i_phase   (w_cur_phase),
        .o_pixel   (w_pixel)
    );

    always_comb begin
        n_active    = r_active;
        n_pending   = r_pending;
        n_phase     = r_phase;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        if (w_accept && (i_in_data.operation == OP_REQUEST)) begin
            if (i_in_data.pattern_request <= PATTERN_MAX) begin
                n_pending = i_in_data.pattern_request;
            end
        end
        if (w_tick) begin
            n_active    = r_pending;
            n_out       = w_pixel;
            n_out_valid = 1'b1;
            if (r_pending == PATTERN_DARK) begin
                n_phase = '0;
            end else if (w_phase_inc >= (PHASE_W + 1)'(CYCLE)) begin
                n_phase = '0;
            end else begin
                n_phase = w_phase_inc[PHASE_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= PATTERN_RESET;
            r_pending   <= PATTERN_RESET;
            r_phase     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_active    <= n_active;
            r_pending   <= n_pending;
            r_phase     <= n_phase;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `LSPS_ASSERT_NOW(a_dark_phase, i_clk, i_rst_n, r_active == PATTERN_DARK, r_phase == '0, "dark pattern with running phase")
    `LSPS_ASSERT_NOW(a_phase_range, i_clk, i_rst_n, 1'b1, {1'b0, r_phase} < (PHASE_W + 1)'(CYCLE), "phase out of range")
    `LSPS_ASSERT_NEXT(a_tick_result, i_clk, i_rst_n, w_tick, r_out_valid && (r_out.active_pattern == r_active), "tick gave no result")
    `LSPS_ASSERT_NEXT(a_request_silent, i_clk, i_rst_n, w_accept && (i_in_data.operation == OP_REQUEST) && !r_out_valid, !r_out_valid, "request gave a result")
    `LSPS_ASSERT_NOW(a_dark_pixel, i_clk, i_rst_n, r_out_valid && (r_out.active_pattern == PATTERN_DARK), (r_out.green_level == '0) && (r_out.red_level == '0) && (r_out.blue_level == '0), "dark pattern lit")

endmodule

// File: sv/lsps_pixel.sv
// pixel color for one pattern and phase: timeline decode, ramp table, color mix
// depends on lsps_pkg
`timescale 1ns / 1ps

module lsps_pixel
    import lsps_pkg::*;
#(
    parameter int SURGE_LENGTH = SURGE_LENGTH_DEF,
    parameter int GAP_LENGTH   = GAP_LENGTH_DEF,
    parameter int REST_LENGTH  = REST_LENGTH_DEF,
    parameter int PHASE_W      = $clog2(2 * SURGE_LENGTH + GAP_LENGTH + REST_LENGTH)
) (
    input  logic [PATTERN_W-1:0] i_pattern,
    input  logic [PHASE_W-1:0]   i_phase,
    output t_out                 o_pixel
);

    localparam int HALF   = SURGE_LENGTH / 2;
    localparam int S_W    = $clog2(SURGE_LENGTH);
    localparam int CMP_W  = PHASE_W + 1;
    localparam int SECOND = SURGE_LENGTH + GAP_LENGTH;
    localparam int END2   = SECOND + SURGE_LENGTH;

    logic [LEVEL_W-1:0] w_ramp [SURGE_LENGTH];

    // triangle ramp, worked out at elaboration
    for (genvar k = 0; k < SURGE_LENGTH; k++) begin : g_ramp
        localparam int RAW = (k < HALF) ? (k * PEAK_LEVEL) / HALF
                                        : ((SURGE_LENGTH - k) * PEAK_LEVEL) / HALF;
        localparam int LVL = (RAW > PEAK_LEVEL) ? PEAK_LEVEL : RAW;
        assign w_ramp[k] = LEVEL_W'(LVL);
    end

    logic [CMP_W-1:0]   w_p;
    logic [CMP_W-1:0]   w_p1;
    logic               w_in0;
    logic               w_in1;
    logic [S_W-1:0]     w_s;
    logic [LEVEL_W-1:0] w_lvl;
    logic [LEVEL_W-1:0] w_half_lvl;
    t_hue               w_hue;

    assign w_p   = {1'b0, i_phase};
    assign w_p1  = w_p - CMP_W'(SECOND);
    assign w_in0 = (w_p < CMP_W'(SURGE_LENGTH));
    assign w_in1 = (w_p >= CMP_W'(SECOND)) && (w_p < CMP_W'(END2));

    always_comb begin
        w_s = w_in0 ? w_p[S_W-1:0] : w_p1[S_W-1:0];
        w_lvl = w_ramp[w_s];
        w_half_lvl = {1'b0, w_lvl[LEVEL_W-1:1]};
        w_hue = (w_in0 || w_in1) ? hue_of(i_pattern, w_in1) : HUE_NONE;

        o_pixel = '0;
        o_pixel.active_pattern = i_pattern;
        case (w_hue)
            HUE_BLUE:   o_pixel.blue_level = w_lvl;
            HUE_RED:    o_pixel.red_level  = w_lvl;
            HUE_GREEN:  o_pixel.green_level = w_lvl;
            HUE_YELLOW: begin
                o_pixel.green_level = w_lvl;
                o_pixel.red_level   = w_lvl;
            end
            HUE_WHITE: begin
                o_pixel.green_level = w_half_lvl;
                o_pixel.red_level   = w_half_lvl;
                o_pixel.blue_level  = w_half_lvl;
            end
            default: o_pixel.active_pattern = i_pattern;
        endcase
    end

endmodule
